// File: hw/rtl/echo_state_reservoir_step_macros.svh
// Assertion macros shared by the reservoir step RTL.
// Needs signals named clock and reset in the module that uses them.
`ifndef ECHO_STATE_RESERVOIR_STEP_MACROS_SVH
`define ECHO_STATE_RESERVOIR_STEP_MACROS_SVH

// same-cycle implication
`define ESR_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ESR_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/esr_pkg.sv
// Shared types, action codes and the tanh approximation for the reservoir step.
// No dependencies.
package esr_pkg;

   localparam logic [2:0] ACT_WIN    = 3'd0;
   localparam logic [2:0] ACT_WRES   = 3'd1;
   localparam logic [2:0] ACT_RBIAS  = 3'd2;
   localparam logic [2:0] ACT_WOUT   = 3'd3;
   localparam logic [2:0] ACT_OBIAS  = 3'd4;
   localparam logic [2:0] ACT_CLEAR  = 3'd5;
   localparam logic [2:0] ACT_SAMPLE = 3'd6;

   localparam int JOB_AW = 16;

   typedef struct packed {
      logic [2:0]         action;
      logic [5:0]         row_index;
      logic [5:0]         col_index;
      logic signed [15:0] value;
      logic               last;
   } req_word_type;

   typedef struct packed {
      logic [1:0]         output_index;
      logic signed [15:0] output_value;
      logic               output_last;
   } rsp_word_type;

   // classified item as handed from front to back
   typedef struct packed {
      logic [2:0]         op;
      logic [JOB_AW-1:0]  addr;
      logic signed [15:0] value;
      logic               store;
      logic               step;
   } job_type;

   localparam logic [12:0] TANH_TAB [21] = '{
      13'd0, 13'd1003, 13'd1893, 13'd2602, 13'd3119, 13'd3475, 13'd3707,
      13'd3856, 13'd3949, 13'd4006, 13'd4041, 13'd4062, 13'd4076, 13'd4084,
      13'd4089, 13'd4091, 13'd4093, 13'd4094, 13'd4095, 13'd4095, 13'd4096
   };

   // odd-symmetric tanh, linear interpolation between quarter-unit points
   function automatic logic signed [15:0] tanh_q(input logic signed [15:0] x);
      logic [16:0] a;
      logic [6:0]  idx;
      logic [9:0]  f;
      logic [12:0] t0;
      logic [12:0] t1;
      logic [10:0] d;
      logic [20:0] p;
      logic [12:0] y;
      a   = x[15] ? (17'd0 - {x[15], x}) : {1'b0, x};
      idx = a[16:10];
      f   = a[9:0];
      t0  = TANH_TAB[idx[4:0]];
      t1  = TANH_TAB[5'(idx[4:0] + 5'd1)];
      d   = 11'(t1 - t0);
      p   = 21'(d * f) + 21'd512;
      if (idx >= 7'd20) begin
         y = 13'd4096;
      end else begin
         y = t0 + 13'(p >> 10);
      end
      return x[15] ? (16'sd0 - signed'({3'b000, y})) : signed'({3'b000, y});
   endfunction

endpackage

// File: hw/rtl/esr_front.sv
// Front end: takes request words, range-checks and decodes them into jobs,
// and queues them for the back end. Depends on esr_pkg.
module esr_front #(
   parameter int RES_SIZE = 64,
   parameter int IN_SIZE  = 8,
   parameter int OUT_SIZE = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  esr_pkg::req_word_type req_data,
   output logic                  job_valid,
   input  logic                  job_pop,
   output esr_pkg::job_type      job_data
);
   import esr_pkg::*;

   localparam int DEPTH = 2;

   job_type    q_ff [DEPTH];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   job_type    job_in;
   logic       keep;
   logic       push;
   logic       pop;
   int         row;
   int         col;

   always_comb begin
      row           = 32'(req_data.row_index);
      col           = 32'(req_data.col_index);
      job_in.op     = req_data.action;
      job_in.value  = req_data.value;
      job_in.store  = 1'b0;
      job_in.step   = 1'b0;
      job_in.addr   = '0;
      keep          = 1'b0;
      unique case (req_data.action)
         ACT_WIN: begin
            keep        = (row < RES_SIZE) && (col < IN_SIZE);
            job_in.addr = JOB_AW'(row * IN_SIZE + col);
         end
         ACT_WRES: begin
            keep        = (row < RES_SIZE) && (col < RES_SIZE);
            job_in.addr = JOB_AW'(row * RES_SIZE + col);
         end
         ACT_RBIAS: begin
            keep        = row < RES_SIZE;
            job_in.addr = JOB_AW'(row);
         end
         ACT_WOUT: begin
            keep        = (row < OUT_SIZE) && (col < RES_SIZE);
            job_in.addr = JOB_AW'(row * RES_SIZE + col);
         end
         ACT_OBIAS: begin
            keep        = row < OUT_SIZE;
            job_in.addr = JOB_AW'(row);
         end
         ACT_CLEAR: begin
            keep = 1'b1;
         end
         ACT_SAMPLE: begin
            job_in.store = col < IN_SIZE;
            job_in.step  = req_data.last;
            job_in.addr  = JOB_AW'(col);
            keep         = job_in.store || job_in.step;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign req_stall = count_ff == 2'(DEPTH);
   assign push      = req_valid && !req_stall && keep;
   assign pop       = job_pop && job_valid;
   assign job_valid = count_ff != 2'd0;
   assign job_data  = q_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= job_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

`include "echo_state_reservoir_step_macros.svh"
   `ESR_ASSERT_IMP(a_count_bound, 1'b1, count_ff <= 2'(DEPTH), "queue count overflow")
   `ESR_ASSERT_NXT(a_push_count, push && !pop, count_ff == $past(count_ff) + 2'd1, "push lost")
   `ESR_ASSERT_NXT(a_pop_count, pop && !push, count_ff == $past(count_ff) - 2'd1, "pop lost")

endmodule

// File: hw/rtl/esr_back.sv
// Back end: weight, bias, buffer and state memories, a shared MAC pipeline
// and the step sequencer; drives the result register. Depends on esr_pkg.
module esr_back #(
   parameter int RES_SIZE = 64,
   parameter int IN_SIZE  = 8,
   parameter int OUT_SIZE = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  job_valid,
   output logic                  job_pop,
   input  esr_pkg::job_type      job_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output esr_pkg::rsp_word_type rsp_data
);
   import esr_pkg::*;

   localparam int RW     = (RES_SIZE > 1) ? $clog2(RES_SIZE) : 1;
   localparam int IW     = (IN_SIZE > 1) ? $clog2(IN_SIZE) : 1;
   localparam int OW     = (OUT_SIZE > 1) ? $clog2(OUT_SIZE) : 1;
   localparam int TW     = $clog2(IN_SIZE + RES_SIZE);
   localparam int WIN_AW = $clog2(RES_SIZE * IN_SIZE);
   localparam int WR_AW  = $clog2(RES_SIZE * RES_SIZE);
   localparam int WO_AW  = (OUT_SIZE * RES_SIZE > 1) ? $clog2(OUT_SIZE * RES_SIZE) : 1;
   localparam int ACC_W  = 33 + $clog2(IN_SIZE + RES_SIZE + 1);
   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sd134217728);
   localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_RES    = 3'd1;
   localparam logic [2:0] ST_RDRAIN = 3'd2;
   localparam logic [2:0] ST_OWAIT  = 3'd3;
   localparam logic [2:0] ST_ORUN   = 3'd4;
   localparam logic [2:0] ST_FIN    = 3'd5;

   localparam logic [1:0] TK_IN  = 2'd0;
   localparam logic [1:0] TK_RES = 2'd1;
   localparam logic [1:0] TK_OUT = 2'd2;

   typedef struct packed {
      logic       vld;
      logic [1:0] kind;
      logic       first;
      logic       last;
      logic [7:0] row;
   } tag_type;

   // memories
   logic signed [15:0] win_mem  [RES_SIZE * IN_SIZE];
   logic signed [15:0] wr_mem   [RES_SIZE * RES_SIZE];
   logic signed [15:0] rb_mem   [RES_SIZE];
   logic signed [15:0] wo_mem   [OUT_SIZE * RES_SIZE];
   logic signed [15:0] ob_mem   [OUT_SIZE];
   logic signed [15:0] buf_mem  [IN_SIZE];
   logic signed [15:0] z_mem    [2**(RW+1)];
   logic [1:0][RES_SIZE-1:0] zvld_ff;

   logic [2:0]    state_ff, state_in;
   logic [RW-1:0] i_ff;
   logic [TW-1:0] t_ff;
   logic [OW-1:0] k_ff;
   logic          bank_ff;

   // issue stage
   tag_type       s0;
   logic          in_term;
   logic [RW-1:0] rcol;
   logic [IW-1:0] u_ra;
   logic [WIN_AW-1:0] win_ra;
   logic [WR_AW-1:0]  wr_ra;
   logic [WO_AW-1:0]  wo_ra;
   logic [RW-1:0]     rb_ra;
   logic [OW-1:0]     ob_ra;
   logic [RW:0]       z_ra;
   logic [RW-1:0]     z_col;

   // pipeline
   tag_type s1_ff, s2_ff, s3_ff, s4_ff;
   logic signed [15:0] win_q, wr_q, wo_q, buf_q, z_q, rb_q, ob_q;
   logic               zv_q;
   logic signed [15:0] wsel, osel, bsel;
   logic signed [31:0] prod_ff;
   logic signed [15:0] bias_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [ACC_W-1:0] bias_ext;
   logic signed [ACC_W-1:0] prod_ext;
   logic signed [ACC_W-1:0] rnd;
   logic signed [15:0] sat;
   logic signed [15:0] rs_ff;
   logic               pipe_empty;
   logic               rsp_valid_ff;
   rsp_word_type       rsp_ff;
   logic               z_we;
   logic [RW:0]        z_wa;

   logic last_term;
   logic last_out_term;

   assign pipe_empty    = !s1_ff.vld && !s2_ff.vld && !s3_ff.vld && !s4_ff.vld;
   assign last_term     = t_ff == TW'(IN_SIZE + RES_SIZE - 1);
   assign last_out_term = t_ff == TW'(RES_SIZE - 1);
   assign job_pop       = (state_ff == ST_IDLE) && job_valid;

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (job_pop && job_data.op == ACT_SAMPLE && job_data.step)
                       state_in = ST_RES;
         ST_RES:    if (last_term && i_ff == RW'(RES_SIZE - 1)) state_in = ST_RDRAIN;
         ST_RDRAIN: if (pipe_empty) state_in = ST_OWAIT;
         ST_OWAIT:  if (pipe_empty && !rsp_valid_ff) state_in = ST_ORUN;
         ST_ORUN:   if (last_out_term)
                       state_in = (k_ff == OW'(OUT_SIZE - 1)) ? ST_FIN : ST_OWAIT;
         ST_FIN:    if (pipe_empty) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff     <= '0;
         t_ff     <= '0;
         k_ff     <= '0;
         bank_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            ST_IDLE: begin
               i_ff <= '0;
               t_ff <= '0;
            end
            ST_RES: begin
               if (last_term) begin
                  t_ff <= '0;
                  i_ff <= i_ff + RW'(1);
               end else begin
                  t_ff <= t_ff + TW'(1);
               end
            end
            ST_RDRAIN: begin
               k_ff <= '0;
               if (pipe_empty) bank_ff <= !bank_ff;
            end
            ST_OWAIT: t_ff <= '0;
            ST_ORUN: begin
               if (last_out_term) k_ff <= k_ff + OW'(1);
               else t_ff <= t_ff + TW'(1);
            end
            default: ;
         endcase
      end
   end

   // issue addresses
   always_comb begin
      in_term = (state_ff == ST_RES) && (t_ff < TW'(IN_SIZE));
      rcol    = in_term ? '0 : RW'(t_ff - TW'(IN_SIZE));
      u_ra    = in_term ? IW'(t_ff) : '0;
      win_ra  = WIN_AW'(32'(i_ff) * IN_SIZE + 32'(u_ra));
      wr_ra   = WR_AW'(32'(i_ff) * RES_SIZE + 32'(rcol));
      wo_ra   = WO_AW'(32'(k_ff) * RES_SIZE + 32'(t_ff));
      rb_ra   = i_ff;
      ob_ra   = k_ff;
      z_col   = (state_ff == ST_ORUN) ? RW'(t_ff) : rcol;
      z_ra    = {bank_ff, z_col};
      s0.vld  = (state_ff == ST_RES) || (state_ff == ST_ORUN);
      if (state_ff == ST_ORUN) begin
         s0.kind  = TK_OUT;
         s0.first = t_ff == '0;
         s0.last  = last_out_term;
         s0.row   = 8'(k_ff);
      end else begin
         s0.kind  = in_term ? TK_IN : TK_RES;
         s0.first = t_ff == '0;
         s0.last  = last_term;
         s0.row   = 8'(i_ff);
      end
   end

   // memory writes and registered reads
   always_ff @(posedge clock) begin
      if (job_pop && job_data.op == ACT_WIN) win_mem[job_data.addr[WIN_AW-1:0]] <= job_data.value;
      win_q <= win_mem[win_ra];
   end

   always_ff @(posedge clock) begin
      if (job_pop && job_data.op == ACT_WRES) wr_mem[job_data.addr[WR_AW-1:0]] <= job_data.value;
      wr_q <= wr_mem[wr_ra];
   end

   always_ff @(posedge clock) begin
      if (job_pop && job_data.op == ACT_RBIAS) rb_mem[job_data.addr[RW-1:0]] <= job_data.value;
      rb_q <= rb_mem[rb_ra];
   end

   always_ff @(posedge clock) begin
      if (job_pop && job_data.op == ACT_WOUT) wo_mem[job_data.addr[WO_AW-1:0]] <= job_data.value;
      wo_q <= wo_mem[wo_ra];
   end

   always_ff @(posedge clock) begin
      if (job_pop && job_data.op == ACT_OBIAS) ob_mem[job_data.addr[OW-1:0]] <= job_data.value;
      ob_q <= ob_mem[ob_ra];
   end

   always_ff @(posedge clock) begin
      if (job_pop && job_data.op == ACT_SAMPLE && job_data.store)
         buf_mem[job_data.addr[IW-1:0]] <= job_data.value;
      buf_q <= buf_mem[u_ra];
   end

   // new state goes to the bank not being read
   assign z_we = s4_ff.vld && (s4_ff.kind != TK_OUT);
   assign z_wa = {!bank_ff, s4_ff.row[RW-1:0]};

   always_ff @(posedge clock) begin
      if (z_we) z_mem[z_wa] <= tanh_q(rs_ff);
      z_q  <= z_mem[z_ra];
      zv_q <= zvld_ff[bank_ff][z_col];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zvld_ff <= '0;
      end else begin
         if (job_pop && job_data.op == ACT_CLEAR) zvld_ff[bank_ff] <= '0;
         if (z_we) zvld_ff[!bank_ff][s4_ff.row[RW-1:0]] <= 1'b1;
      end
   end

   // operand select and multiply
   always_comb begin
      case (s1_ff.kind)
         TK_IN:   wsel = win_q;
         TK_RES:  wsel = wr_q;
         default: wsel = wo_q;
      endcase
      osel = (s1_ff.kind == TK_IN) ? buf_q : (zv_q ? z_q : 16'sd0);
      bsel = (s1_ff.kind == TK_OUT) ? ob_q : rb_q;
   end

   always_ff @(posedge clock) begin
      prod_ff <= wsel * osel;
      bias_ff <= bsel;
   end

   // accumulate, round and saturate
   assign bias_ext = signed'({{(ACC_W-28){bias_ff[15]}}, bias_ff, 12'd0});
   assign prod_ext = signed'({{(ACC_W-32){prod_ff[31]}}, prod_ff});
   assign rnd      = acc_ff + ACC_W'(2048);

   always_comb begin
      if (rnd >= SAT_HI) begin
         sat = 16'sd32767;
      end else if (rnd < SAT_LO) begin
         sat = -16'sd32768;
      end else begin
         sat = rnd[27:12];
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ff.vld) begin
         acc_ff <= s2_ff.first ? (bias_ext + prod_ext) : (acc_ff + prod_ext);
      end
      if (s3_ff.vld && s3_ff.last) rs_ff <= sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
         s2_ff <= '0;
         s3_ff <= '0;
         s4_ff <= '0;
      end else begin
         s1_ff <= s0;
         s2_ff <= s1_ff;
         s3_ff <= s2_ff;
         // only the last term of a row moves on to the write-back stage
         s4_ff <= '{vld: s3_ff.vld && s3_ff.last, kind: s3_ff.kind, first: s3_ff.first,
                    last: s3_ff.last, row: s3_ff.row};
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (s4_ff.vld && s4_ff.kind == TK_OUT) begin
         rsp_ff.output_index <= s4_ff.row[1:0];
         rsp_ff.output_value <= rs_ff;
         rsp_ff.output_last  <= s4_ff.row == 8'(OUT_SIZE - 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s4_ff.vld && s4_ff.kind == TK_OUT) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`include "echo_state_reservoir_step_macros.svh"
   `ESR_ASSERT_IMP(a_rsp_slot_free, s4_ff.vld && s4_ff.kind == TK_OUT, !rsp_valid_ff, "readout overwrote pending result")
   `ESR_ASSERT_IMP(a_idle_drained, state_ff == ST_IDLE, pipe_empty, "pipeline busy in idle")
   `ESR_ASSERT_NXT(a_bank_flip, state_ff == ST_RDRAIN && pipe_empty, bank_ff != $past(bank_ff), "state bank not flipped")
   `ESR_ASSERT_IMP(a_no_state_write_out, z_we, state_ff == ST_RES || state_ff == ST_RDRAIN, "state written outside reservoir pass")

endmodule

// File: hw/rtl/echo_state_reservoir_step.sv
// Top level of the echo state network reservoir step.
// Instantiates esr_front (decode and job queue) and esr_back (MAC engine); uses esr_pkg.
//
//   port group   dir   payload         handshake
//   req_*        in    req_word_type   req_valid / req_stall
//   rsp_*        out   rsp_word_type   rsp_valid / rsp_stall
//
// A weight, bias, clear or sample word is taken by the back end only while it is idle.
// A step runs one multiply-accumulate per cycle on the single shared MAC, except while it
// waits for the pipeline to drain or for a pending result to be taken.
// Reset clears the state valid bits, so the reservoir state reads zero; no clearing pass.
// The two-entry job queue holds up to two words while the back end runs a step.
// A stalled result holds the next readout row from starting.
module echo_state_reservoir_step #(
   parameter int RES_SIZE = 64,
   parameter int IN_SIZE  = 8,
   parameter int OUT_SIZE = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  esr_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output esr_pkg::rsp_word_type rsp_data
);
   import esr_pkg::*;

   logic    job_valid;
   logic    job_pop;
   job_type job_data;

   esr_front #(
      .RES_SIZE (RES_SIZE),
      .IN_SIZE  (IN_SIZE),
      .OUT_SIZE (OUT_SIZE)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .job_valid (job_valid),
      .job_pop   (job_pop),
      .job_data  (job_data)
   );

   esr_back #(
      .RES_SIZE (RES_SIZE),
      .IN_SIZE  (IN_SIZE),
      .OUT_SIZE (OUT_SIZE)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job_pop   (job_pop),
      .job_data  (job_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// File: sim/tb_echo_state_reservoir_step.sv
// Testbench for echo_state_reservoir_step: loads weights, runs network steps and
// checks every readout word against a behavioral predictor. Uses esr_pkg.
module tb_echo_state_reservoir_step;
   import esr_pkg::*;

   localparam int RES_SIZE = 64;
   localparam int IN_SIZE  = 8;
   localparam int OUT_SIZE = 4;
   localparam int STEP_CYCLES = RES_SIZE * (IN_SIZE + RES_SIZE) + OUT_SIZE * (RES_SIZE + 6) + 6;
   localparam longint CYCLE_LIMIT = 20000000;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_word_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_word_type rsp_data;

   echo_state_reservoir_step #(
      .RES_SIZE(RES_SIZE), .IN_SIZE(IN_SIZE), .OUT_SIZE(OUT_SIZE)
   ) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   // predictor copy of the network
   logic signed [15:0] w_in   [RES_SIZE*IN_SIZE];
   logic signed [15:0] w_res  [RES_SIZE*RES_SIZE];
   logic signed [15:0] b_res  [RES_SIZE];
   logic signed [15:0] w_out  [OUT_SIZE*RES_SIZE];
   logic signed [15:0] b_out  [OUT_SIZE];
   logic signed [15:0] neuron [RES_SIZE];
   logic signed [15:0] sample [IN_SIZE];

   rsp_word_type readout_queue[$];
   int     mismatches;
   longint cycles;
   bit     hold_rsp;
   int     hold_len;

   const int unsigned TANH_PTS[21] = '{0, 1003, 1893, 2602, 3119, 3475, 3707, 3856,
      3949, 4006, 4041, 4062, 4076, 4084, 4089, 4091, 4093, 4094, 4095, 4095, 4096};

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic logic signed [15:0] round_q312(longint acc);
      longint r;
      r = acc + 2048;
      if (r >= 64'sd134217728) return 16'sh7fff;
      if (r < -64'sd134217728) return -16'sh8000;
      return 16'(r >>> 12);
   endfunction

   function automatic logic signed [15:0] squash(logic signed [15:0] x);
      int a, idx, f, y;
      a = (x < 0) ? -int'(x) : int'(x);
      idx = a >> 10;
      f = a & 1023;
      if (idx >= 20) y = 4096;
      else y = TANH_PTS[idx] + (((int'(TANH_PTS[idx+1]) - int'(TANH_PTS[idx])) * f + 512) >> 10);
      return (x < 0) ? 16'(-y) : 16'(y);
   endfunction

   task automatic predict_word(req_word_type w);
      logic signed [15:0] nxt[RES_SIZE];
      longint acc;
      rsp_word_type r;
      case (w.action)
         ACT_WIN:    if (w.col_index < IN_SIZE) w_in[w.row_index*IN_SIZE + w.col_index] = w.value;
         ACT_WRES:   w_res[w.row_index*RES_SIZE + w.col_index] = w.value;
         ACT_RBIAS:  b_res[w.row_index] = w.value;
         ACT_WOUT:   if (w.row_index < OUT_SIZE) w_out[w.row_index*RES_SIZE + w.col_index] = w.value;
         ACT_OBIAS:  if (w.row_index < OUT_SIZE) b_out[w.row_index] = w.value;
         ACT_CLEAR:  foreach (neuron[i]) neuron[i] = 0;
         ACT_SAMPLE: begin
            if (w.col_index < IN_SIZE) sample[w.col_index] = w.value;
            if (w.last) begin
               for (int i = 0; i < RES_SIZE; i++) begin
                  acc = longint'(b_res[i]) * 4096;
                  for (int j = 0; j < IN_SIZE; j++)
                     acc += longint'(w_in[i*IN_SIZE + j]) * sample[j];
                  for (int j = 0; j < RES_SIZE; j++)
                     acc += longint'(w_res[i*RES_SIZE + j]) * neuron[j];
                  nxt[i] = squash(round_q312(acc));
               end
               neuron = nxt;
               for (int k = 0; k < OUT_SIZE; k++) begin
                  acc = longint'(b_out[k]) * 4096;
                  for (int j = 0; j < RES_SIZE; j++)
                     acc += longint'(w_out[k*RES_SIZE + j]) * neuron[j];
                  r.output_index = 2'(k);
                  r.output_value = round_q312(acc);
                  r.output_last  = (k == OUT_SIZE - 1);
                  readout_queue.push_back(r);
               end
            end
         end
         default: ;
      endcase
   endtask

   function automatic int gap_len();
      if ($urandom_range(0, 2) == 0) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
      return $urandom_range(1, 4);
   endfunction

   // driven at the falling edge, so a plain assignment cannot race the sampling edge
   task automatic send_word(req_word_type w);
      int g;
      g = gap_len();
      repeat (g) @(negedge clock);
      req_data  = w;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      predict_word(w);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   function automatic req_word_type mk(logic [2:0] a, int row, int col, int v, int l);
      req_word_type w;
      w.action = a; w.row_index = 6'(row); w.col_index = 6'(col);
      w.value = 16'(v); w.last = 1'(l);
      return w;
   endfunction

   function automatic int rand_weight(int span);
      return $urandom_range(0, 2 * span) - span;
   endfunction

   task automatic drain();
      while (readout_queue.size() != 0) @(negedge clock);
   endtask

   // every store written before any step reads it
   task automatic test_load_all(int span);
      for (int i = 0; i < RES_SIZE; i++) begin
         send_word(mk(ACT_RBIAS, i, $urandom_range(0, 63), rand_weight(span), $urandom_range(0, 1)));
         for (int j = 0; j < IN_SIZE; j++)
            send_word(mk(ACT_WIN, i, j, rand_weight(span), 0));
         for (int j = 0; j < RES_SIZE; j++)
            send_word(mk(ACT_WRES, i, j, rand_weight(span / 4), 0));
      end
      for (int k = 0; k < OUT_SIZE; k++) begin
         send_word(mk(ACT_OBIAS, k, 0, rand_weight(span), 0));
         for (int j = 0; j < RES_SIZE; j++)
            send_word(mk(ACT_WOUT, k, j, rand_weight(span), 0));
      end
      for (int j = 0; j < IN_SIZE; j++)
         send_word(mk(ACT_SAMPLE, 0, j, rand_weight(span), 0));
   endtask

   task automatic test_directed();
      send_word(mk(ACT_SAMPLE, 0, 0, 32767, 0));
      send_word(mk(ACT_SAMPLE, 0, 7, -32768, 1));
      send_word(mk(ACT_CLEAR, 0, 0, 0, 1));
      send_word(mk(ACT_SAMPLE, 63, 63, 1234, 1));  // out-of-range column still steps
      send_word(mk(3'd7, 63, 63, -1, 1));          // unused code
      send_word(mk(ACT_WIN, 5, 8, 777, 0));         // ignored columns
      send_word(mk(ACT_WIN, 5, 63, 777, 0));
      send_word(mk(ACT_WOUT, 4, 0, -32768, 0));     // ignored rows
      send_word(mk(ACT_OBIAS, 63, 0, 32767, 0));
      send_word(mk(ACT_OBIAS, 3, 0, 32767, 1));
      send_word(mk(ACT_RBIAS, 63, 0, -32768, 0));
      send_word(mk(ACT_WRES, 63, 63, 32767, 0));
      send_word(mk(ACT_WOUT, 3, 63, 32767, 0));
      send_word(mk(ACT_WIN, 0, 0, -32768, 0));
      send_word(mk(ACT_SAMPLE, 0, 3, 16'h5555, 1));
      send_word(mk(ACT_SAMPLE, 0, 4, 16'haaaa, 1));
      drain();
   endtask

   task automatic test_random(int count);
      int sel;
      for (int n = 0; n < count; n++) begin
         sel = $urandom_range(0, 9);
         if (sel < 5)
            send_word(mk(ACT_SAMPLE, $urandom_range(0, 63), $urandom_range(0, IN_SIZE - 1),
                         $urandom_range(0, 65535), $urandom_range(0, 3) == 0));
         else if (sel == 5)
            send_word(mk(ACT_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63), $urandom, $urandom));
         else if (sel == 6)
            send_word(mk(3'($urandom_range(0, 4)), $urandom_range(0, 63), $urandom_range(0, 63),
                         $urandom_range(0, 65535), $urandom));
         else if (sel == 7)
            send_word(mk(3'd7, $urandom_range(0, 63), $urandom_range(0, 63), $urandom, $urandom));
         else
            send_word(mk(ACT_SAMPLE, $urandom_range(0, 63), $urandom_range(0, 63),
                         $urandom_range(0, 65535), 1));
      end
   endtask

   // receiver blocks while several steps queue up behind it
   task automatic test_backpressure();
      hold_len = 3 * STEP_CYCLES;
      hold_rsp = 1'b1;
      for (int n = 0; n < 4; n++)
         send_word(mk(ACT_SAMPLE, 0, $urandom_range(0, IN_SIZE - 1), $urandom_range(0, 65535), 1));
      wait (!hold_rsp);
      drain();
   endtask

   // readout side
   initial begin
      rsp_stall = 1'b0;
      hold_rsp  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            repeat (hold_len) @(negedge clock);
            hold_rsp = 1'b0;
            rsp_stall <= 1'b0;
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat (gap_len() + 1) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // readout checker
   initial begin
      rsp_word_type want;
      mismatches = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (readout_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected readout word %p", rsp_data);
            end else begin
               want = readout_queue.pop_front();
               if (rsp_data.output_index !== want.output_index ||
                   rsp_data.output_value !== want.output_value ||
                   rsp_data.output_last  !== want.output_last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("readout mismatch: expected %p got %p", want, rsp_data);
               end
            end
         end
      end
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      foreach (neuron[i]) neuron[i] = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_load_all(16384);
      test_directed();
      test_backpressure();
      test_random(60);
      drain();
      test_load_all(32767);  // extreme weights drive saturation
      test_random(40);
      drain();
      repeat (STEP_CYCLES + 100) @(posedge clock);
      if (mismatches == 0 && readout_queue.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end
endmodule
